/* hw/rtl/aps_pkg.sv */
// Shared types and constants for the aging priority task scheduler.
// No dependencies; used by aps_div and the scheduler core.
package aps_pkg;

   localparam int TASK_COUNT = 16;
   localparam int IDX_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
   localparam logic [8:0] QUOT_MAX = 9'd511;
   localparam logic [15:0] AGING_RESET = 16'd100;

   localparam logic [2:0] OP_TICK    = 3'd0;
   localparam logic [2:0] OP_LOAD    = 3'd1;
   localparam logic [2:0] OP_SCHED   = 3'd2;
   localparam logic [2:0] OP_BLOCK   = 3'd3;
   localparam logic [2:0] OP_UNBLOCK = 3'd4;

   localparam logic [1:0] ST_FREE    = 2'd0;
   localparam logic [1:0] ST_READY   = 2'd1;
   localparam logic [1:0] ST_RUNNING = 2'd2;
   localparam logic [1:0] ST_BLOCKED = 2'd3;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_EMPTY   = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;

   typedef struct packed {
      logic [2:0] opcode;
      logic [3:0] task_id;
      logic [7:0] task_priority;
   } req_type;

   typedef struct packed {
      logic [3:0] running_id;
      logic       running_valid;
      logic [1:0] status_code;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  state;
      logic [7:0]  prio;
      logic [31:0] wake_tick;
      logic [31:0] stamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

/* hw/rtl/aps_ram.sv */
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module aps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/aps_div.sv */
// Saturating age / interval divider, one quotient bit per cycle.
// Depends on aps_pkg for the quotient limit.
module aps_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] age,
   input  logic [15:0] interval,
   output logic        done,
   output logic [8:0]  quot
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [3:0]  bit_ff, bit_in;
   logic [24:0] rem_ff, rem_in;
   logic [15:0] div_ff, div_in;
   logic [8:0]  quot_ff, quot_in;
   logic [15:0] iv;
   logic [24:0] shifted;

   always_comb begin
      iv = (interval == 16'd0) ? 16'd1 : interval;
      shifted = {9'd0, div_ff} << bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      bit_in = bit_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      quot_in = quot_ff;
      if (start) begin
         div_in = iv;
         // age >= 512 * iv saturates
         if (age[31:9] >= {7'd0, iv}) begin
            quot_in = aps_pkg::QUOT_MAX;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            rem_in = age[24:0];
            quot_in = 9'd0;
            bit_in = 4'd8;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (rem_ff >= shifted) begin
            rem_in = rem_ff - shifted;
            quot_in[bit_ff] = 1'b1;
         end
         if (bit_ff == 4'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            bit_in = bit_ff - 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      bit_ff <= bit_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

/* hw/rtl/aging_priority_task_scheduler_core.sv */
// Aging priority task scheduler: task table in RAM, sequencer, result register.
// Tick goes straight to the response; load/unblock read and rewrite one entry. Schedule/block
// first requeue or block the running task (schedule skips this when nothing runs), then scan
// TASK_COUNT RAM reads, each ready entry running the 9-step divider. One transaction at a time.
// Reset: synchronous; clears control, counters and per-entry valid bits
// (entries never written read as free), no clearing pass.
module aging_priority_task_scheduler_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  aps_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output aps_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [15:0]      csr_data
);

   localparam int IW = aps_pkg::IDX_W;

   typedef enum logic [3:0] {
      S_IDLE, S_ID_WAIT, S_ID_CHK, S_CUR_WAIT, S_CUR_CHK,
      S_SCAN_WAIT, S_SCAN_CHK, S_DIV, S_PICK, S_RESP
   } state_type;

   state_type state_ff;
   logic [15:0] aging_ff;
   logic [31:0] tick_ff, stamp_ff;
   logic [IW-1:0] cur_ff, addr_ff, best_ff;
   logic cur_valid_ff, found_ff;
   logic [2:0] op_ff;
   logic [7:0] prio_ff;
   logic [1:0] status_ff;
   logic signed [9:0] best_pts_ff;
   logic [31:0] best_wait_ff;
   aps_pkg::entry_type best_ent_ff, cand_ff;
   logic [aps_pkg::TASK_COUNT-1:0] valid_ff;
   logic rsp_valid_ff;
   aps_pkg::rsp_type rsp_ff;

   logic wr_en;
   logic [IW-1:0] wr_addr;
   aps_pkg::entry_type wr_ent, rd_ent;
   logic [aps_pkg::ENTRY_W-1:0] rd_raw;
   logic [1:0] rd_state;
   logic div_start, div_done;
   logic [8:0] div_quot;
   logic signed [9:0] pts;
   logic [31:0] wait_cnt;
   logic better, last;

   aps_ram #(.WIDTH(aps_pkg::ENTRY_W), .DEPTH(aps_pkg::TASK_COUNT)) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_ent),
      .rd_addr(addr_ff),
      .rd_data(rd_raw)
   );

   aps_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .age     (tick_ff - rd_ent.wake_tick),
      .interval(aging_ff),
      .done    (div_done),
      .quot    (div_quot)
   );

   always_comb begin
      rd_ent = rd_raw;
      rd_state = valid_ff[addr_ff] ? rd_ent.state : aps_pkg::ST_FREE;
      last = (addr_ff == IW'(aps_pkg::TASK_COUNT - 1));
      pts = $signed({2'b00, cand_ff.prio}) - $signed({1'b0, div_quot});
      wait_cnt = stamp_ff - cand_ff.stamp;
      better = !found_ff || (pts < best_pts_ff) ||
               ((pts == best_pts_ff) && (wait_cnt > best_wait_ff));
      div_start = (state_ff == S_SCAN_CHK) && (rd_state == aps_pkg::ST_READY);
      wr_en = 1'b0;
      wr_addr = addr_ff;
      wr_ent = rd_ent;
      case (state_ff)
         S_ID_CHK: begin
            if ((op_ff == aps_pkg::OP_LOAD && rd_state == aps_pkg::ST_FREE) ||
                (op_ff == aps_pkg::OP_UNBLOCK && rd_state == aps_pkg::ST_BLOCKED)) begin
               wr_en = 1'b1;
               wr_ent.state = aps_pkg::ST_READY;
               if (op_ff == aps_pkg::OP_LOAD) begin
                  wr_ent.prio = prio_ff;
               end
               wr_ent.wake_tick = tick_ff;
               wr_ent.stamp = stamp_ff;
            end
         end
         S_CUR_CHK: begin
            if (op_ff == aps_pkg::OP_BLOCK) begin
               wr_en = 1'b1;
               wr_ent.state = aps_pkg::ST_BLOCKED;
            end else if (rd_state == aps_pkg::ST_RUNNING) begin
               wr_en = 1'b1;
               wr_ent.state = aps_pkg::ST_READY;
               wr_ent.wake_tick = tick_ff;
               wr_ent.stamp = stamp_ff;
            end
         end
         S_PICK: begin
            wr_en = found_ff;
            wr_addr = best_ff;
            wr_ent = best_ent_ff;
            wr_ent.state = aps_pkg::ST_RUNNING;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         aging_ff <= aps_pkg::AGING_RESET;
         tick_ff <= 32'd0;
         stamp_ff <= 32'd0;
         cur_ff <= '0;
         cur_valid_ff <= 1'b0;
         found_ff <= 1'b0;
         valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            aging_ff <= csr_data;
         end
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         // S_RESP handles its own handshake below
         if (rsp_valid_ff && !rsp_stall && state_ff != S_RESP) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff <= req_data.opcode;
                  prio_ff <= req_data.task_priority;
                  status_ff <= aps_pkg::STATUS_OK;
                  addr_ff <= '0;
                  found_ff <= 1'b0;
                  state_ff <= S_RESP;
                  case (req_data.opcode)
                     aps_pkg::OP_TICK: tick_ff <= tick_ff + 32'd1;
                     aps_pkg::OP_LOAD, aps_pkg::OP_UNBLOCK: begin
                        if ({28'd0, req_data.task_id} < 32'(aps_pkg::TASK_COUNT)) begin
                           addr_ff <= IW'(req_data.task_id);
                           state_ff <= S_ID_WAIT;
                        end else begin
                           status_ff <= aps_pkg::STATUS_INVALID;
                        end
                     end
                     aps_pkg::OP_SCHED: begin
                        if (cur_valid_ff) begin
                           addr_ff <= cur_ff;
                           state_ff <= S_CUR_WAIT;
                        end else begin
                           state_ff <= S_SCAN_WAIT;
                        end
                     end
                     aps_pkg::OP_BLOCK: begin
                        if (cur_valid_ff) begin
                           addr_ff <= cur_ff;
                           state_ff <= S_CUR_WAIT;
                        end else begin
                           status_ff <= aps_pkg::STATUS_INVALID;
                        end
                     end
                     default: status_ff <= aps_pkg::STATUS_INVALID;
                  endcase
               end
            end
            S_ID_WAIT: state_ff <= S_ID_CHK;
            S_ID_CHK: begin
               if (wr_en) begin
                  stamp_ff <= stamp_ff + 32'd1;
               end else begin
                  status_ff <= aps_pkg::STATUS_INVALID;
               end
               state_ff <= S_RESP;
            end
            S_CUR_WAIT: state_ff <= S_CUR_CHK;
            S_CUR_CHK: begin
               if (wr_en && op_ff == aps_pkg::OP_SCHED) begin
                  stamp_ff <= stamp_ff + 32'd1;
               end
               cur_valid_ff <= 1'b0;
               addr_ff <= '0;
               state_ff <= S_SCAN_WAIT;
            end
            S_SCAN_WAIT: state_ff <= S_SCAN_CHK;
            S_SCAN_CHK: begin
               cur_valid_ff <= 1'b0;
               if (div_start) begin
                  cand_ff <= rd_ent;
                  state_ff <= S_DIV;
               end else if (last) begin
                  state_ff <= S_PICK;
               end else begin
                  addr_ff <= addr_ff + IW'(1);
                  state_ff <= S_SCAN_WAIT;
               end
            end
            S_DIV: begin
               if (div_done) begin
                  if (better) begin
                     found_ff <= 1'b1;
                     best_pts_ff <= pts;
                     best_wait_ff <= wait_cnt;
                     best_ff <= addr_ff;
                     best_ent_ff <= cand_ff;
                  end
                  if (last) begin
                     state_ff <= S_PICK;
                  end else begin
                     addr_ff <= addr_ff + IW'(1);
                     state_ff <= S_SCAN_WAIT;
                  end
               end
            end
            S_PICK: begin
               if (found_ff) begin
                  cur_ff <= best_ff;
                  cur_valid_ff <= 1'b1;
               end else begin
                  status_ff <= aps_pkg::STATUS_EMPTY;
               end
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff.running_id <= cur_valid_ff ? 4'(cur_ff) : 4'd0;
                  rsp_ff.running_valid <= cur_valid_ff;
                  rsp_ff.status_code <= status_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign csr_ready = 1'b1;

endmodule

/* tb/sv/aging_priority_task_scheduler_core_test.sv */
// Testbench for the aging priority task scheduler core: directed table, then random traffic.
// Depends on aps_pkg and aging_priority_task_scheduler_core; self-checking against a local model.
module aging_priority_task_scheduler_core_test;
   import aps_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 600;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [15:0] csr_data = '0;

   aging_priority_task_scheduler_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // scheduler model state
   logic [15:0] interval_reg;
   logic [1:0]  task_st [TASK_COUNT];
   logic [7:0]  task_prio [TASK_COUNT];
   logic [31:0] task_wake_tick [TASK_COUNT];
   logic [31:0] task_stamp [TASK_COUNT];
   logic [31:0] tick_now;
   logic [31:0] stamp_now;
   logic [3:0]  run_id;
   logic        run_valid;

   rsp_type expected_rsp [$];
   int errors = 0;
   int idle_cycles = 0;
   bit hold_off = 1'b0;
   bit press_go = 1'b0;

   function automatic void model_reset();
      interval_reg = AGING_RESET;
      for (int i = 0; i < TASK_COUNT; i++) task_st[i] = ST_FREE;
      tick_now = '0;
      stamp_now = '0;
      run_id = '0;
      run_valid = 1'b0;
   endfunction

   function automatic void enqueue_task(int t);
      task_st[t] = ST_READY;
      task_wake_tick[t] = tick_now;
      task_stamp[t] = stamp_now;
      stamp_now = stamp_now + 1;
   endfunction

   function automatic logic [1:0] pick_next();
      logic [31:0] iv, q, wait_ticks, best_wait;
      int pts, best_pts, best;
      bit found;
      iv = (interval_reg == 0) ? 32'd1 : {16'd0, interval_reg};
      found = 1'b0;
      best_pts = 0;
      best_wait = '0;
      best = 0;
      if (run_valid && task_st[run_id] == ST_RUNNING) enqueue_task(run_id);
      run_valid = 1'b0;
      for (int t = 0; t < TASK_COUNT; t++) begin
         if (task_st[t] == ST_READY) begin
            q = (tick_now - task_wake_tick[t]) / iv;
            if (q > 32'(QUOT_MAX)) q = 32'(QUOT_MAX);
            pts = int'(task_prio[t]) - int'(q);
            wait_ticks = stamp_now - task_stamp[t];
            if (!found || pts < best_pts || (pts == best_pts && wait_ticks > best_wait)) begin
               found = 1'b1;
               best_pts = pts;
               best_wait = wait_ticks;
               best = t;
            end
         end
      end
      if (!found) return STATUS_EMPTY;
      task_st[best] = ST_RUNNING;
      run_id = 4'(best);
      run_valid = 1'b1;
      return STATUS_OK;
   endfunction

   function automatic rsp_type predict_schedule(req_type r);
      rsp_type o;
      logic [1:0] status;
      status = STATUS_OK;
      case (r.opcode)
         OP_TICK: tick_now = tick_now + 1;
         OP_LOAD: begin
            if (task_st[r.task_id] != ST_FREE) status = STATUS_INVALID;
            else begin
               task_prio[r.task_id] = r.task_priority;
               enqueue_task(r.task_id);
            end
         end
         OP_SCHED: status = pick_next();
         OP_BLOCK: begin
            if (!run_valid) status = STATUS_INVALID;
            else begin
               task_st[run_id] = ST_BLOCKED;
               run_valid = 1'b0;
               status = pick_next();
            end
         end
         OP_UNBLOCK: begin
            if (task_st[r.task_id] != ST_BLOCKED) status = STATUS_INVALID;
            else enqueue_task(r.task_id);
         end
         default: status = STATUS_INVALID;
      endcase
      o.running_id = run_valid ? run_id : 4'd0;
      o.running_valid = run_valid;
      o.status_code = status;
      return o;
   endfunction

   // receiver: random stall, long hold-off on request, check on acceptance
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected result %p", $time, rsp_data);
            errors++;
         end else begin
            rsp_type e;
            e = expected_rsp.pop_front();
            if (rsp_data.running_id !== e.running_id)
               $display("%0t: running_id expected %0d actual %0d", $time, e.running_id,
                        rsp_data.running_id);
            if (rsp_data.running_valid !== e.running_valid)
               $display("%0t: running_valid expected %0d actual %0d", $time,
                        e.running_valid, rsp_data.running_valid);
            if (rsp_data.status_code !== e.status_code)
               $display("%0t: status_code expected %0d actual %0d", $time, e.status_code,
                        rsp_data.status_code);
            if (rsp_data !== e) errors++;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_off) rsp_stall <= 1'b1;
      else if ($urandom_range(0, 99) < 3) rsp_stall <= 1'b1;
      else if ($urandom_range(0, 99) < 30) rsp_stall <= ($urandom_range(0, 99) < 40);
      else rsp_stall <= 1'b0;
   end

   // watchdog on cycles with no transaction
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("aging_priority_task_scheduler_core_test: done, errors");
         $finish;
      end
   end

   task automatic send_req(req_type r, bit check_fixed, rsp_type fixed);
      rsp_type p;
      req_data <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      p = predict_schedule(r);
      if (check_fixed && p !== fixed) begin
         $display("%0t: table row expected %p, model gives %p", $time, fixed, p);
         errors++;
      end
      expected_rsp.push_back(p);
      @(negedge clock);
      if ($urandom_range(0, 99) < 35) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 99) < 90 ? $urandom_range(1, 3) : $urandom_range(10, 60))
            @(negedge clock);
      end
   endtask

   task automatic write_interval(logic [15:0] v);
      req_valid <= 1'b0;
      wait (expected_rsp.size() == 0);
      @(negedge clock);
      csr_data <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      interval_reg = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic req_type mk(logic [2:0] op, logic [3:0] id, logic [7:0] pr);
      req_type r;
      r.opcode = op;
      r.task_id = id;
      r.task_priority = pr;
      return r;
   endfunction

   function automatic rsp_type rs(logic [3:0] id, logic v, logic [1:0] s);
      rsp_type o;
      o.running_id = id;
      o.running_valid = v;
      o.status_code = s;
      return o;
   endfunction

   typedef struct {
      req_type r;
      bit      fixed;
      rsp_type o;
   } table_row;

   initial begin
      table_row rows [$];
      req_type r;
      logic [2:0] op;
      int n;
      model_reset();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      rows.push_back('{mk(OP_SCHED, 4'd0, 8'd0), 1, rs(4'd0, 1'b0, STATUS_EMPTY)});
      rows.push_back('{mk(OP_BLOCK, 4'd0, 8'd0), 1, rs(4'd0, 1'b0, STATUS_INVALID)});
      rows.push_back('{mk(OP_UNBLOCK, 4'd15, 8'd0), 1, rs(4'd0, 1'b0, STATUS_INVALID)});
      rows.push_back('{mk(3'd5, 4'd0, 8'd0), 1, rs(4'd0, 1'b0, STATUS_INVALID)});
      rows.push_back('{mk(3'd7, 4'd15, 8'd255), 1, rs(4'd0, 1'b0, STATUS_INVALID)});
      rows.push_back('{mk(OP_TICK, 4'd15, 8'd255), 1, rs(4'd0, 1'b0, STATUS_OK)});
      rows.push_back('{mk(OP_LOAD, 4'd15, 8'd255), 0, '0});
      rows.push_back('{mk(OP_LOAD, 4'd0, 8'd0), 0, '0});
      rows.push_back('{mk(OP_LOAD, 4'd0, 8'd7), 1, rs(4'd0, 1'b0, STATUS_INVALID)});
      rows.push_back('{mk(OP_LOAD, 4'd5, 8'd0), 0, '0});
      rows.push_back('{mk(OP_SCHED, 4'd0, 8'd0), 1, rs(4'd0, 1'b1, STATUS_OK)});
      rows.push_back('{mk(OP_SCHED, 4'd0, 8'd0), 1, rs(4'd5, 1'b1, STATUS_OK)});
      rows.push_back('{mk(OP_BLOCK, 4'd0, 8'd0), 0, '0});
      rows.push_back('{mk(OP_UNBLOCK, 4'd5, 8'd0), 0, '0});
      rows.push_back('{mk(OP_UNBLOCK, 4'd5, 8'd0), 0, '0});
      rows.push_back('{mk(OP_BLOCK, 4'd0, 8'd0), 0, '0});
      rows.push_back('{mk(OP_BLOCK, 4'd0, 8'd0), 0, '0});
      rows.push_back('{mk(OP_BLOCK, 4'd0, 8'd0), 0, '0});
      rows.push_back('{mk(OP_SCHED, 4'd0, 8'd0), 0, '0});
      rows.push_back('{mk(OP_UNBLOCK, 4'd15, 8'd0), 0, '0});
      rows.push_back('{mk(OP_SCHED, 4'd0, 8'd0), 0, '0});
      foreach (rows[i]) send_req(rows[i].r, rows[i].fixed, rows[i].o);

      // aging at the fastest and slowest rates, then random and middle ones; interval 0 acts as 1
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: write_interval(16'd1);
            1: write_interval(16'd0);
            2: write_interval(16'hFFFF);
            3: write_interval(16'($urandom_range(2, 40)));
            default: write_interval(16'd3);
         endcase
         n = (phase == 4) ? 100 : 50;
         if (phase == 2) press_go = 1'b1;
         for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 99)) inside
               [0:29]:  op = OP_TICK;
               [30:49]: op = OP_LOAD;
               [50:69]: op = OP_SCHED;
               [70:82]: op = OP_BLOCK;
               [83:96]: op = OP_UNBLOCK;
               default: op = 3'($urandom_range(5, 7));
            endcase
            r = mk(op, 4'($urandom), 8'($urandom));
            // long tick bursts push the aging quotient toward saturation
            if (op == OP_TICK && phase < 2 && $urandom_range(0, 9) == 0)
               repeat ($urandom_range(20, 60)) send_req(mk(OP_TICK, 4'($urandom),
                                                           8'($urandom)), 0, '0);
            send_req(r, 0, '0);
         end
      end
      req_valid <= 1'b0;
      wait (expected_rsp.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && expected_rsp.size() == 0)
         $display("aging_priority_task_scheduler_core_test: done, clean");
      else
         $display("aging_priority_task_scheduler_core_test: done, errors");
      $finish;
   end

   // the hold-off while the sender keeps offering: count cycles in this process
   initial begin
      @(posedge press_go);
      hold_off = 1'b1;
      repeat (300) @(posedge clock);
      hold_off = 1'b0;
   end

endmodule
